>>> sv/glcm_pkg.sv
// Shared types, constants and the microcode program of the gcd/lcm unit.
// No dependencies; every other file imports this package.
package glcm_pkg;

  // Operand width, field width on the stream bus and magnitude width
  localparam int DW   = 64;
  localparam int FW   = 64;
  localparam int VW   = DW - 1;
  localparam int CW   = $clog2(VW);
  localparam int PCW  = 4;
  localparam int OUT_VALW    = 63;
  localparam int IN_TDATA_W  = 2 * FW;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD     = OUT_TDATA_W - OUT_VALW - 2;

  typedef logic [VW-1:0]  mag_t;
  typedef logic [PCW-1:0] pc_t;
  typedef logic [3:0]     op_t;
  typedef logic [2:0]     cond_t;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_VALUE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // Datapath operations
  localparam op_t OP_NOP    = 4'd0;
  localparam op_t OP_LOAD   = 4'd1;
  localparam op_t OP_DIVMOD = 4'd2;
  localparam op_t OP_EUCLID = 4'd3;
  localparam op_t OP_DIVQ   = 4'd4;
  localparam op_t OP_MUL    = 4'd5;
  localparam op_t OP_OUTGCD = 4'd6;
  localparam op_t OP_OUTLCM = 4'd7;
  localparam op_t OP_OUTBAD = 4'd8;

  // Jump conditions
  localparam cond_t C_NEVER   = 3'd0;
  localparam cond_t C_ALWAYS  = 3'd1;
  localparam cond_t C_NOACC   = 3'd2;
  localparam cond_t C_BAD     = 3'd3;
  localparam cond_t C_BZERO   = 3'd4;
  localparam cond_t C_BUSY    = 3'd5;
  localparam cond_t C_LCM     = 3'd6;
  localparam cond_t C_OUTPEND = 3'd7;

  // Program addresses that are jump targets
  localparam pc_t S_LOAD    = 4'd0;
  localparam pc_t S_LOOP    = 4'd2;
  localparam pc_t S_MODWAIT = 4'd4;
  localparam pc_t S_GDONE   = 4'd6;
  localparam pc_t S_LCM     = 4'd8;
  localparam pc_t S_QWAIT   = 4'd9;
  localparam pc_t S_MWAIT   = 4'd11;
  localparam pc_t S_BAD     = 4'd13;
  localparam pc_t S_OUTWAIT = 4'd15;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt;
  } uword_t;

  typedef struct packed {
    logic noacc;
    logic bad;
    logic bzero;
    logic busy;
    logic lcm;
    logic outpend;
  } seq_flags_t;

  typedef struct packed {
    logic start;
    logic mul;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic ovf;
  } arith_rsp_t;

  // Microcode ROM: jump to tgt when cond holds, else step to pc + 1.
  // The last step falls through to address zero by wrap.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{OP_LOAD,   C_NOACC,   S_LOAD};
      4'd1:    w = '{OP_NOP,    C_BAD,     S_BAD};
      4'd2:    w = '{OP_NOP,    C_BZERO,   S_GDONE};
      4'd3:    w = '{OP_DIVMOD, C_NEVER,   S_LOAD};
      4'd4:    w = '{OP_NOP,    C_BUSY,    S_MODWAIT};
      4'd5:    w = '{OP_EUCLID, C_ALWAYS,  S_LOOP};
      4'd6:    w = '{OP_NOP,    C_LCM,     S_LCM};
      4'd7:    w = '{OP_OUTGCD, C_ALWAYS,  S_OUTWAIT};
      4'd8:    w = '{OP_DIVQ,   C_NEVER,   S_LOAD};
      4'd9:    w = '{OP_NOP,    C_BUSY,    S_QWAIT};
      4'd10:   w = '{OP_MUL,    C_NEVER,   S_LOAD};
      4'd11:   w = '{OP_NOP,    C_BUSY,    S_MWAIT};
      4'd12:   w = '{OP_OUTLCM, C_ALWAYS,  S_OUTWAIT};
      4'd13:   w = '{OP_OUTBAD, C_ALWAYS,  S_OUTWAIT};
      4'd15:   w = '{OP_NOP,    C_OUTPEND, S_OUTWAIT};
      default: w = '{OP_NOP,    C_ALWAYS,  S_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> sv/glcm_seq.sv
// Microcode sequencer: step counter, program ROM lookup and jump logic.
// Depends on glcm_pkg.
module glcm_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  glcm_pkg::seq_flags_t  flags_i,
  output glcm_pkg::op_t         op_o
);
  import glcm_pkg::*;

  pc_t    pc_r, pc_nxt;
  uword_t uw;
  logic   take;

  // Fetch and condition select
  always_comb begin
    uw = ucode(pc_r);
    case (uw.cond)
      C_NEVER:   take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_NOACC:   take = flags_i.noacc;
      C_BAD:     take = flags_i.bad;
      C_BZERO:   take = flags_i.bzero;
      C_BUSY:    take = flags_i.busy;
      C_LCM:     take = flags_i.lcm;
      C_OUTPEND: take = flags_i.outpend;
      default:   take = 1'b0;
    endcase
    pc_nxt = take ? uw.tgt : pc_r + PCW'(1);
    op_o   = uw.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> sv/glcm_arith.sv
// Iterative arithmetic unit: restoring divider and MSB-first shift-add
// multiplier with sticky overflow, one bit per cycle. Depends on glcm_pkg.
module glcm_arith (
  input  logic                  clk,
  input  logic                  rst_n,
  input  glcm_pkg::arith_req_t  req_i,
  input  glcm_pkg::mag_t        opa_i,   // dividend or multiplier
  input  glcm_pkg::mag_t        opb_i,   // divisor or multiplicand
  output glcm_pkg::arith_rsp_t  rsp_o,
  output glcm_pkg::mag_t        quo_o,
  output glcm_pkg::mag_t        rem_o    // remainder or product
);
  import glcm_pkg::*;

  logic          busy_r, busy_nxt;
  logic          mul_r, mul_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  mag_t          quo_r, quo_nxt;
  mag_t          rem_r, rem_nxt;
  mag_t          div_r, div_nxt;
  logic          ovf_r, ovf_nxt;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic [VW+1:0] sum;

  // One step of either operation
  always_comb begin
    trial = {rem_r, quo_r[VW-1]};
    diff  = trial - {1'b0, div_r};
    sum   = {1'b0, rem_r, 1'b0} + {2'b00, (quo_r[VW-1] ? div_r : '0)};

    busy_nxt = busy_r;
    mul_nxt  = mul_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    ovf_nxt  = ovf_r;

    if (req_i.start) begin
      busy_nxt = 1'b1;
      mul_nxt  = req_i.mul;
      cnt_nxt  = CW'(VW - 1);
      quo_nxt  = opa_i;
      div_nxt  = opb_i;
      rem_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      if (mul_r) begin
        rem_nxt = sum[VW-1:0];
        ovf_nxt = ovf_r | (|sum[VW+1:VW]);
        quo_nxt = {quo_r[VW-2:0], 1'b0};
      end else if (!diff[VW]) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[VW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[VW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp_o = '{busy: busy_r, ovf: ovf_r};
  assign quo_o = quo_r;
  assign rem_o = rem_r;

endmodule

>>> sv/integer_gcd_lcm_unit_top.sv
// Gcd/lcm unit top level: operand registers, output register and the
// sequencer and arithmetic unit. Depends on glcm_pkg, glcm_seq, glcm_arith.
//
// Usage: one word on the in_ stream carries two signed operands and an
// action in in_tuser (0 gcd, 1 lcm). One word on the out_ stream answers
// it with the value and a status (ok, operand not positive, lcm overflow).
// Both operands must be above zero, else the status is bad value at once.
// The gcd runs the Euclidean remainder loop; every remainder takes one pass
// of the bit-serial divider plus the sequencing steps around it; an item
// needs one such pass per Euclid iteration: a few iterations for typical
// data, up to about 92 for worst-case 63-bit operands. An lcm adds one
// divide and one multiply pass. A bad operand goes from the load step
// through the bad-value check straight to the output step.
// One item is in work at a time;
// in_tready is high only while the sequencer waits at its load step.
// The result sits in an output register; while the receiver stalls it
// holds, and the next item is taken once that word has left.
// Reset (synchronous, active low) returns the sequencer to the load step
// and empties the output register.
module integer_gcd_lcm_unit_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [63:0] first_operand, [127:64] second_operand
  input  logic [glcm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] action
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [62:0] value, [64:63] status, [71:65] zero
  output logic [glcm_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import glcm_pkg::*;

  op_t        op;
  seq_flags_t flags;
  arith_req_t areq;
  arith_rsp_t arsp;
  mag_t       aquo, arem;
  mag_t       opa, opb;

  mag_t        a_r, a_nxt;
  mag_t        b_r, b_nxt;
  mag_t        y_r, y_nxt;
  mag_t        x_r, x_nxt;
  logic        lcm_r, lcm_nxt;
  logic        bad_r, bad_nxt;
  logic        out_valid_r, out_valid_nxt;
  mag_t        out_value_r, out_value_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  logic [DW-1:0] y_raw, x_raw;
  logic          in_acc, out_acc, out_load;

  assign in_tready = (op == OP_LOAD);
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_valid_r & out_tready;
  assign y_raw     = in_tdata[DW-1:0];
  assign x_raw     = in_tdata[FW+DW-1:FW];

  glcm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .flags_i (flags),
    .op_o    (op)
  );

  glcm_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (areq),
    .opa_i (opa),
    .opb_i (opb),
    .rsp_o (arsp),
    .quo_o (aquo),
    .rem_o (arem)
  );

  // Sequencer flags
  always_comb begin
    flags.noacc   = ~in_acc;
    flags.bad     = bad_r;
    flags.bzero   = (b_r == '0);
    flags.busy    = arsp.busy;
    flags.lcm     = lcm_r;
    flags.outpend = out_valid_r;
  end

  // Arithmetic unit requests and operand select
  always_comb begin
    areq.start = op inside {OP_DIVMOD, OP_DIVQ, OP_MUL};
    areq.mul   = (op == OP_MUL);
    case (op)
      OP_DIVQ: begin
        opa = y_r;
        opb = a_r;
      end
      OP_MUL: begin
        opa = aquo;
        opb = x_r;
      end
      default: begin
        opa = a_r;
        opb = b_r;
      end
    endcase
  end

  // Operand registers and output register
  always_comb begin
    a_nxt          = a_r;
    b_nxt          = b_r;
    y_nxt          = y_r;
    x_nxt          = x_r;
    lcm_nxt        = lcm_r;
    bad_nxt        = bad_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r & ~out_acc;
    out_load       = 1'b0;

    case (op)
      OP_LOAD: begin
        if (in_acc) begin
          y_nxt   = y_raw[VW-1:0];
          x_nxt   = x_raw[VW-1:0];
          lcm_nxt = in_tuser;
          // positive means nonzero with a clear sign bit
          bad_nxt = y_raw[DW-1] | x_raw[DW-1] | (y_raw == '0) | (x_raw == '0);
          // smaller operand first
          if (y_raw[VW-1:0] > x_raw[VW-1:0]) begin
            a_nxt = x_raw[VW-1:0];
            b_nxt = y_raw[VW-1:0];
          end else begin
            a_nxt = y_raw[VW-1:0];
            b_nxt = x_raw[VW-1:0];
          end
        end
      end
      OP_EUCLID: begin
        a_nxt = b_r;
        b_nxt = arem;
      end
      OP_OUTGCD: begin
        out_load       = 1'b1;
        out_value_nxt  = a_r;
        out_status_nxt = ST_OK;
      end
      OP_OUTLCM: begin
        out_load       = 1'b1;
        out_value_nxt  = arsp.ovf ? '0 : arem;
        out_status_nxt = arsp.ovf ? ST_OVERFLOW : ST_OK;
      end
      OP_OUTBAD: begin
        out_load       = 1'b1;
        out_value_nxt  = '0;
        out_status_nxt = ST_BAD_VALUE;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    y_r          <= y_nxt;
    x_r          <= x_nxt;
    lcm_r        <= lcm_nxt;
    bad_r        <= bad_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_status_r, OUT_VALW'(out_value_r)};

  // A new item is only taken once the previous result has left
  a_in_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !out_valid_r)
    else $error("input accepted while a result is pending");

  // The sequencer never restarts the arithmetic unit mid-operation
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    areq.start |-> !arsp.busy)
    else $error("arithmetic unit started while busy");

  // A result is never written over one not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r)
    else $error("output register overwritten");

  // Any non-ok status carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("error status with nonzero value");

endmodule
